### rtl/core/tsg_pkg.sv
// ----------------------------------------------------------------------------
// tsg_pkg
// Shared types and codes for the top-k score group table.
// ----------------------------------------------------------------------------
`default_nettype none

package tsg_pkg;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_READ   = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_NONE   = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_NEW_GROUP = 3'd0,
    ST_JOINED    = 3'd1,
    ST_DROPPED   = 3'd2,
    ST_EVICTED   = 3'd3,
    ST_READ_OK   = 3'd4,
    ST_READ_OOR  = 3'd5,
    ST_CLEARED   = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE   = 2'd0,
    FSM_FIND   = 2'd1,
    FSM_UPDATE = 2'd2,
    FSM_RESP   = 2'd3
  } fsm_e;

  typedef struct packed {
    logic latch;   // capture the input beat
    logic find;    // parallel compare, register match and insert position
    logic update;  // modify table, access doc memory
    logic resp;    // present result
  } cmd_t;

endpackage

`default_nettype wire

### rtl/core/tsg_ram.sv
// ----------------------------------------------------------------------------
// tsg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tsg_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 800
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                         wdata_i,
  input  wire logic                                     re_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

### rtl/core/tsg_ctrl.sv
// ----------------------------------------------------------------------------
// tsg_ctrl
// Sequencer: idle, find, update, respond.
// ----------------------------------------------------------------------------
`default_nettype none

module tsg_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  output logic               done_o,
  output tsg_pkg::cmd_t      cmd_o
);

  tsg_pkg::fsm_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tsg_pkg::FSM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      tsg_pkg::FSM_IDLE:   if (start) state_d = tsg_pkg::FSM_FIND;
      tsg_pkg::FSM_FIND:   state_d = tsg_pkg::FSM_UPDATE;
      tsg_pkg::FSM_UPDATE: state_d = tsg_pkg::FSM_RESP;
      tsg_pkg::FSM_RESP:   state_d = tsg_pkg::FSM_IDLE;
      default:             state_d = tsg_pkg::FSM_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy   = 1'b1;
    done_o = 1'b0;
    case (state_q)
      tsg_pkg::FSM_IDLE: begin
        busy        = 1'b0;
        cmd_o.latch = start;
      end
      tsg_pkg::FSM_FIND:   cmd_o.find = 1'b1;
      tsg_pkg::FSM_UPDATE: cmd_o.update = 1'b1;
      tsg_pkg::FSM_RESP: begin
        cmd_o.resp = 1'b1;
        done_o     = 1'b1;
      end
      default: busy = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/tsg_dp.sv
// ----------------------------------------------------------------------------
// tsg_dp
// Datapath: sorted group registers, rank-to-bank map and doc id memory.
// ----------------------------------------------------------------------------
`default_nettype none

module tsg_dp #(
  parameter int MAX_GROUPS = 16,
  parameter int GROUP_DOCS = 50,
  parameter int DOC_BITS   = 24
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire tsg_pkg::cmd_t cmd_i,
  input  wire logic [1:0]    kind_i,
  input  wire logic [31:0]   score_i,
  input  wire logic [23:0]   doc_id_i,
  input  wire logic [3:0]    read_rank_i,
  input  wire logic [5:0]    read_slot_i,
  output logic      [2:0]    status_o,
  output logic      [4:0]    group_total_o,
  output logic      [31:0]   min_score_o,
  output logic      [31:0]   read_score_o,
  output logic      [23:0]   read_doc_o,
  output logic      [5:0]    read_size_o
);

  localparam int CNT_W  = $clog2(MAX_GROUPS + 1);
  localparam int PHYS_W = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int SIZE_W = $clog2(GROUP_DOCS + 1);
  localparam int DEPTH  = MAX_GROUPS * GROUP_DOCS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // table state, rank order
  logic [31:0]       score_q [MAX_GROUPS];
  logic [SIZE_W-1:0] size_q  [MAX_GROUPS];
  logic [PHYS_W-1:0] map_q   [MAX_GROUPS];  // rank -> doc memory bank
  logic [CNT_W-1:0]  count_q;
  logic [31:0]       lowest_q;

  // latched beat
  tsg_pkg::kind_e    kind_q;
  logic [31:0]       score_in_q;
  logic [DOC_BITS-1:0] doc_q;
  logic [3:0]        rank_q;
  logic [5:0]        slot_q;

  // find results
  logic              hit_q, full_grp_q, evict_q, read_ok_q;
  logic [PHYS_W-1:0] hidx_q, pos_q, cnt_eff_q, phys_q;
  logic [ADDR_W-1:0] addr_q;
  logic [31:0]       rscore_q;
  logic [SIZE_W-1:0] rsize_q;

  // result registers
  tsg_pkg::status_e  status_q;
  logic              rd_out_q;

  logic [DOC_BITS-1:0] ram_rdata;
  logic [31:0]         doc_wide;
  logic [31:0]         rdoc_wide;

  assign doc_wide = {8'd0, doc_id_i};

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      kind_q     <= tsg_pkg::kind_e'(kind_i);
      score_in_q <= score_i;
      doc_q      <= doc_wide[DOC_BITS-1:0];
      rank_q     <= read_rank_i;
      slot_q     <= read_slot_i;
    end
  end

  // ---------------- find ----------------
  logic              hit_c, evict_c, read_ok_c, rank_ok_c;
  logic [PHYS_W-1:0] hidx_c, pos_c, cnt_eff_c, ridx_c, bank_c;
  logic [CNT_W-1:0]  cnt_eff_n;
  logic [SIZE_W-1:0] slot_sel_c;
  logic [ADDR_W-1:0] addr_c;

  always_comb begin
    evict_c   = (count_q == CNT_W'(MAX_GROUPS));
    cnt_eff_n = evict_c ? CNT_W'(MAX_GROUPS - 1) : count_q;
    cnt_eff_c = cnt_eff_n[PHYS_W-1:0];
    hit_c     = 1'b0;
    hidx_c    = '0;
    pos_c     = cnt_eff_c;
    for (int i = MAX_GROUPS - 1; i >= 0; i--) begin
      if ((CNT_W'(i) < count_q) && (score_q[i] == score_in_q)) begin
        hit_c  = 1'b1;
        hidx_c = PHYS_W'(i);
      end
      if ((CNT_W'(i) < cnt_eff_n) && (score_q[i] < score_in_q)) begin
        pos_c = PHYS_W'(i);
      end
    end
    ridx_c    = PHYS_W'(rank_q);
    rank_ok_c = (8'(rank_q) < 8'(count_q));
    read_ok_c = rank_ok_c && (8'(slot_q) < 8'(size_q[ridx_c]))
                && (8'(slot_q) < 8'(GROUP_DOCS));
    // doc memory address: bank * GROUP_DOCS + slot
    case (kind_q)
      tsg_pkg::KIND_INSERT: begin
        if (hit_c) begin
          bank_c     = map_q[hidx_c];
          slot_sel_c = size_q[hidx_c];
        end else begin
          bank_c     = map_q[cnt_eff_c];
          slot_sel_c = '0;
        end
      end
      default: begin
        bank_c     = map_q[ridx_c];
        slot_sel_c = SIZE_W'(slot_q);
      end
    endcase
    addr_c = ADDR_W'(bank_c) * ADDR_W'(GROUP_DOCS) + ADDR_W'(slot_sel_c);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.find) begin
      hit_q      <= hit_c;
      hidx_q     <= hidx_c;
      full_grp_q <= (32'(size_q[hidx_c]) >= 32'(GROUP_DOCS));
      evict_q    <= evict_c;
      pos_q      <= pos_c;
      cnt_eff_q  <= cnt_eff_c;
      phys_q     <= map_q[cnt_eff_c];
      addr_q     <= addr_c;
      read_ok_q  <= read_ok_c && (kind_q == tsg_pkg::KIND_READ);
      rscore_q   <= read_ok_c ? score_q[ridx_c] : 32'd0;
      rsize_q    <= read_ok_c ? size_q[ridx_c] : '0;
    end
  end

  // ---------------- update ----------------
  logic do_ins, do_join, ram_we, ram_re;
  logic [31:0] last_score_c;

  assign do_ins  = cmd_i.update && (kind_q == tsg_pkg::KIND_INSERT) && !hit_q;
  assign do_join = cmd_i.update && (kind_q == tsg_pkg::KIND_INSERT) && hit_q && !full_grp_q;
  assign ram_we  = do_ins || do_join;
  assign ram_re  = cmd_i.update && read_ok_q;

  // after the shift the last held group sits at cnt_eff
  always_comb begin
    if (pos_q == cnt_eff_q) begin
      last_score_c = score_in_q;
    end else begin
      last_score_c = score_q[PHYS_W'(cnt_eff_q - PHYS_W'(1))];
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_ins) begin
      for (int i = 1; i < MAX_GROUPS; i++) begin
        if ((PHYS_W'(i) > pos_q) && (PHYS_W'(i) <= cnt_eff_q)) begin
          score_q[i] <= score_q[i-1];
          size_q[i]  <= size_q[i-1];
        end
      end
      score_q[pos_q] <= score_in_q;
      size_q[pos_q]  <= SIZE_W'(1);
    end else if (do_join) begin
      size_q[hidx_q] <= size_q[hidx_q] + SIZE_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_GROUPS; i++) begin
        map_q[i] <= PHYS_W'(i);
      end
      count_q  <= '0;
      lowest_q <= '0;
    end else if (do_ins) begin
      // rotate the freed bank into the insert position; map stays a permutation
      for (int i = 1; i < MAX_GROUPS; i++) begin
        if ((PHYS_W'(i) > pos_q) && (PHYS_W'(i) <= cnt_eff_q)) begin
          map_q[i] <= map_q[i-1];
        end
      end
      map_q[pos_q] <= phys_q;
      count_q      <= CNT_W'(cnt_eff_q) + CNT_W'(1);
      lowest_q     <= last_score_c;
    end else if (cmd_i.update && (kind_q == tsg_pkg::KIND_CLEAR)) begin
      count_q  <= '0;
      lowest_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      rd_out_q <= read_ok_q;
      case (kind_q)
        tsg_pkg::KIND_INSERT: begin
          if (hit_q) begin
            status_q <= full_grp_q ? tsg_pkg::ST_DROPPED : tsg_pkg::ST_JOINED;
          end else begin
            status_q <= evict_q ? tsg_pkg::ST_EVICTED : tsg_pkg::ST_NEW_GROUP;
          end
        end
        tsg_pkg::KIND_READ:  status_q <= read_ok_q ? tsg_pkg::ST_READ_OK
                                                   : tsg_pkg::ST_READ_OOR;
        tsg_pkg::KIND_CLEAR: status_q <= tsg_pkg::ST_CLEARED;
        default:             status_q <= tsg_pkg::ST_READ_OOR;
      endcase
    end
  end

  tsg_ram #(
    .WIDTH (DOC_BITS),
    .DEPTH (DEPTH)
  ) u_doc_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q),
    .wdata_i (doc_q),
    .re_i    (ram_re),
    .raddr_i (addr_q),
    .rdata_o (ram_rdata)
  );

  assign rdoc_wide     = rd_out_q ? 32'(ram_rdata) : 32'd0;
  assign status_o      = status_q;
  assign group_total_o = 5'(count_q);
  assign min_score_o   = lowest_q;
  assign read_score_o  = rd_out_q ? rscore_q : 32'd0;
  assign read_doc_o    = rdoc_wide[23:0];
  assign read_size_o   = rd_out_q ? 6'(rsize_q) : 6'd0;

endmodule

`default_nettype wire

### rtl/core/topk_score_groups.sv
// ----------------------------------------------------------------------------
// topk_score_groups
// Sorted table of score groups with per-group document id lists.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Every command passes
// through an accept step, a find step in which all held scores are
// compared in parallel, an update step that shifts the sorted group
// registers and accesses the doc id memory, and a result step in which
// done_o is high for one cycle with the result. The receiver cannot stall;
// the result must be taken when done_o is high. Doc ids are not moved on
// insert: a rank-to-bank map selects each group's region of the memory.
// No clearing pass is needed after reset.
`default_nettype none

module topk_score_groups #(
  parameter int MAX_GROUPS = 16,
  parameter int GROUP_DOCS = 50,
  parameter int DOC_BITS   = 24
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  kind_i,
  input  wire logic [31:0] score_i,
  input  wire logic [23:0] doc_id_i,
  input  wire logic [3:0]  read_rank_i,
  input  wire logic [5:0]  read_slot_i,
  output logic             done_o,
  output logic [2:0]       status_o,
  output logic [4:0]       group_total_o,
  output logic [31:0]      min_score_o,
  output logic [31:0]      read_score_o,
  output logic [23:0]      read_doc_o,
  output logic [5:0]       read_size_o
);

  tsg_pkg::cmd_t cmd;

  tsg_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd)
  );

  tsg_dp #(
    .MAX_GROUPS (MAX_GROUPS),
    .GROUP_DOCS (GROUP_DOCS),
    .DOC_BITS   (DOC_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .kind_i        (kind_i),
    .score_i       (score_i),
    .doc_id_i      (doc_id_i),
    .read_rank_i   (read_rank_i),
    .read_slot_i   (read_slot_i),
    .status_o      (status_o),
    .group_total_o (group_total_o),
    .min_score_o   (min_score_o),
    .read_score_o  (read_score_o),
    .read_doc_o    (read_doc_o),
    .read_size_o   (read_size_o)
  );

endmodule

`default_nettype wire

### rtl/core/tsg_checker.sv
// ----------------------------------------------------------------------------
// tsg_checker
// Port-level checks for the score group table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tsg_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done_o,
  input wire logic [2:0]  status_o,
  input wire logic [4:0]  group_total_o,
  input wire logic [31:0] min_score_o,
  input wire logic [31:0] read_score_o,
  input wire logic [23:0] read_doc_o,
  input wire logic [5:0]  read_size_o
);

  // result beat follows accept after the find and update states
  a_done_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> ##2 done_o)
    else $error("result beat not three cycles after accept");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result beat while idle");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == tsg_pkg::ST_CLEARED) |->
      (group_total_o == 5'd0 && min_score_o == 32'd0))
    else $error("clear left groups held");

  a_oor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != tsg_pkg::ST_READ_OK) |->
      (read_score_o == 32'd0 && read_doc_o == 24'd0 && read_size_o == 6'd0))
    else $error("read fields set without a good read");

  a_empty_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && group_total_o == 5'd0) |-> (min_score_o == 32'd0))
    else $error("minimum nonzero on empty table");

endmodule

bind topk_score_groups tsg_checker u_tsg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .done_o        (done_o),
  .status_o      (status_o),
  .group_total_o (group_total_o),
  .min_score_o   (min_score_o),
  .read_score_o  (read_score_o),
  .read_doc_o    (read_doc_o),
  .read_size_o   (read_size_o)
);

`default_nettype wire
